// File: hw/rtl/rmth_pkg.sv
// Package: shared types and constants for the running median unit.
package rmth_pkg;
	localparam int SampleW = 32;
	localparam int MedW    = 33;
	localparam int HeldW   = 11;

	typedef logic signed [SampleW-1:0] sample_t;

	// Beat passed from one cell to the next: a sample shifting along the row.
	typedef struct packed {
		logic    vld;
		sample_t val;
	} shift_t;

	// Control sent to every cell in the row.
	typedef struct packed {
		logic    ins;
		sample_t val;
	} row_ctl_t;
endpackage

// File: hw/rtl/rmth_cell.sv
// Cell: holds one stored sample, kept sorted ascending along the row.
module rmth_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  rmth_pkg::row_ctl_t ctl,
	input  rmth_pkg::shift_t  prev,
	output rmth_pkg::shift_t  cur
);
	import rmth_pkg::*;

	shift_t slot_q;
	logic   take_new;
	logic   shift_in;
	logic   here_gt;

	assign here_gt  = slot_q.vld && (slot_q.val > ctl.val);
	assign shift_in = prev.vld && (prev.val > ctl.val);
	assign take_new = here_gt && !shift_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q.vld <= 1'b0;
			slot_q.val <= '0;
		end else if (ctl.ins) begin
			if (shift_in) begin
				slot_q <= prev;
			end else if (take_new || !slot_q.vld) begin
				if (!slot_q.vld && prev.vld && !shift_in) begin
					slot_q.vld <= 1'b1;
					slot_q.val <= ctl.val;
				end else if (take_new) begin
					slot_q.val <= ctl.val;
				end
			end
		end
	end

	assign cur = slot_q;
endmodule

// File: hw/rtl/running_median_two_heaps_unit.sv
// Top level: running median over a sorted row of sample cells.
//  channel | dir | tdata (low bit up)                    | notes
//  s_axis  | in  | sample[31:0]                           | one sample per beat
//  m_axis  | out | median_twice[32:0], held[43:33], dropped[44], pad | one per beat
// One sample at a time: accept and insert, read the middle cells, hand out the result.
// Result valid in OUT, after the MID state registers the sum of the middle cells.
// The row shifts every larger sample up one cell at once, as the sample is inserted.
// Reset clears all cell valid bits and the count; no clearing pass.
// Output register holds a result under stall; next sample waits for it.
module running_median_two_heaps_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // median_twice, held, dropped
);
	import rmth_pkg::*;

	localparam int CntW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {IDLE, MID, OUT} st_t;
	st_t st_q;

	row_ctl_t          ctl;
	shift_t            chain [CAPACITY+1];
	logic [CntW-1:0]   cnt_q;
	logic              drop_q;
	logic [MedW-1:0]   med_q;
	logic [CntW-1:0]   lo_idx;
	logic [CntW-1:0]   hi_idx;
	logic              accept;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (st_q == IDLE);
	assign ctl.ins       = accept && (cnt_q < CntW'(CAPACITY));
	assign ctl.val       = sample_t'(s_axis_tdata);
	// Cell 0 sees an always-valid left neighbour holding the minimum value.
	assign chain[0].vld  = 1'b1;
	assign chain[0].val  = {1'b1, {(SampleW-1){1'b0}}};

	genvar g;
	for (g = 0; g < CAPACITY; g++) begin : g_row
		rmth_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.prev  (chain[g]),
			.cur   (chain[g+1])
		);
	end

	assign lo_idx = (cnt_q - CntW'(1)) >> 1;
	assign hi_idx = cnt_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= IDLE;
			cnt_q  <= '0;
			drop_q <= 1'b0;
			med_q  <= '0;
		end else begin
			case (st_q)
				IDLE: begin
					if (accept) begin
						drop_q <= !ctl.ins;
						if (ctl.ins) cnt_q <= cnt_q + CntW'(1);
						st_q <= MID;
					end
				end
				MID: begin
					med_q <= MedW'(chain[lo_idx+CntW'(1)].val)
						+ MedW'(chain[hi_idx+CntW'(1)].val);
					st_q <= OUT;
				end
				OUT: begin
					if (m_axis_tready) st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = (st_q == OUT);
	assign m_axis_tdata  = {3'b0, drop_q, HeldW'(cnt_q), med_q};
endmodule

// File: hw/rtl/rmth_chk.sv
// Checker: port-level properties of the running median unit.
module rmth_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while result pending");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
		else $error("result late");
endmodule

bind running_median_two_heaps_unit rmth_chk u_chk (.*);
